// File: design/sac_pkg.sv
// Shared types and constants of the stick axis conditioner.
// Used by the axis pipeline, the top level and the port checker.
package sac_pkg;

    localparam int NUM_STAGES = 8;
    localparam int DIV_FIRST = 2;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS = 4;
    localparam int NUM_AXES = 4;
    localparam int GAIN_FRAC = 8;

    localparam logic [14:0] AXIS_MAX = 15'd32767;
    localparam logic [15:0] AXIS_MAX_S = 16'h7FFF;
    localparam logic [15:0] AXIS_MIN_S = 16'h8000;
    localparam logic [22:0] GAIN_POS_LIMIT = 23'd32767;
    localparam logic [22:0] GAIN_NEG_LIMIT = 23'd32768;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_DZ = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_DZ = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_GAIN = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_GAIN = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_THR = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT = 8'd6;

    localparam logic [14:0] RST_DEAD_ZONE = 15'd4096;
    localparam logic [15:0] RST_GAIN = 16'd256;
    localparam logic [7:0] RST_TRIG_THR = 8'd30;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    typedef struct packed {
        logic        enable;
        logic [14:0] dz_thr;
        logic [15:0] gain;
        logic        invert;
    } t_axis_cfg;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
    } t_trig_pair;

endpackage

// File: design/stick_axis_conditioner_core.sv
// A report passes dead zone, divider setup, divider, gain and output stages in turn.
// Throughput: one report per cycle while the output is not stalled; the rescale divider is
// pipelined over four stages of four quotient bits in each axis.
// Stalls at the output back up stage by stage; empty stages still take words.
// Reset (synchronous, active low) clears the stage valid bits and loads the register
// defaults. No clearing pass is needed.
module stick_axis_conditioner_core
    import sac_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [15:0]     i_raw_left_x,
    input  logic signed [15:0]     i_raw_left_y,
    input  logic signed [15:0]     i_raw_right_x,
    input  logic signed [15:0]     i_raw_right_y,
    input  logic [7:0]             i_raw_left_trigger,
    input  logic [7:0]             i_raw_right_trigger,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [15:0]     o_out_left_x,
    output logic signed [15:0]     o_out_left_y,
    output logic signed [15:0]     o_out_right_x,
    output logic signed [15:0]     o_out_right_y,
    output logic [7:0]             o_out_left_trigger,
    output logic [7:0]             o_out_right_trigger
);

    logic        r_enable;
    logic [14:0] r_left_dz;
    logic [14:0] r_right_dz;
    logic [15:0] r_left_gain;
    logic [15:0] r_right_gain;
    logic [7:0]  r_trig_thr;
    logic [3:0]  r_invert;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_left_dz <= RST_DEAD_ZONE;
            r_right_dz <= RST_DEAD_ZONE;
            r_left_gain <= RST_GAIN;
            r_right_gain <= RST_GAIN;
            r_trig_thr <= RST_TRIG_THR;
            r_invert <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_LEFT_DZ: r_left_dz <= i_cfg_data[14:0];
                CFG_RIGHT_DZ: r_right_dz <= i_cfg_data[14:0];
                CFG_LEFT_GAIN: r_left_gain <= i_cfg_data;
                CFG_RIGHT_GAIN: r_right_gain <= i_cfg_data;
                CFG_TRIG_THR: r_trig_thr <= i_cfg_data[7:0];
                CFG_INVERT: r_invert <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    logic [NUM_STAGES-1:0] r_valid;
    t_stage_en             stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_in_ready = stage_en[0];
    assign o_out_valid = r_valid[NUM_STAGES-1];

    t_trig_pair r_trig [NUM_STAGES];
    t_trig_pair n_trig;

    always_comb begin
        n_trig.left = i_raw_left_trigger;
        n_trig.right = i_raw_right_trigger;
        if (r_enable && (i_raw_left_trigger < r_trig_thr)) begin
            n_trig.left = '0;
        end
        if (r_enable && (i_raw_right_trigger < r_trig_thr)) begin
            n_trig.right = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_trig[0] <= n_trig;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                r_trig[k] <= r_trig[k-1];
            end
        end
    end

    assign o_out_left_trigger = r_trig[NUM_STAGES-1].left;
    assign o_out_right_trigger = r_trig[NUM_STAGES-1].right;

    logic signed [15:0] raw_axis [NUM_AXES];
    logic signed [15:0] out_axis [NUM_AXES];
    t_axis_cfg          axis_cfg [NUM_AXES];

    assign raw_axis[0] = i_raw_left_x;
    assign raw_axis[1] = i_raw_left_y;
    assign raw_axis[2] = i_raw_right_x;
    assign raw_axis[3] = i_raw_right_y;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        always_comb begin
            axis_cfg[i].enable = r_enable;
            axis_cfg[i].dz_thr = (i < 2) ? r_left_dz : r_right_dz;
            axis_cfg[i].gain = (i < 2) ? r_left_gain : r_right_gain;
            axis_cfg[i].invert = r_invert[i];
        end

        sac_axis_pipe u_axis (
            .i_clk  (i_clk),
            .i_en   (stage_en),
            .i_cfg  (axis_cfg[i]),
            .i_raw  (raw_axis[i]),
            .o_axis (out_axis[i])
        );
    end

    assign o_out_left_x = out_axis[0];
    assign o_out_left_y = out_axis[1];
    assign o_out_right_x = out_axis[2];
    assign o_out_right_y = out_axis[3];

endmodule

// File: design/sac_axis_pipe.sv
// Eight-stage pipeline for one stick axis: dead zone, rescale division, gain, inversion.
// Depends on sac_pkg; stage enables and configuration come from the top level.
module sac_axis_pipe
    import sac_pkg::*;
(
    input  logic               i_clk,
    input  t_stage_en          i_en,
    input  t_axis_cfg          i_cfg,
    input  logic signed [15:0] i_raw,
    output logic signed [15:0] o_axis
);

    typedef struct packed {
        logic [15:0] raw;
        logic        neg;
        logic        zero;
    } t_axis_side;

    t_axis_side  r_side [NUM_STAGES-1];
    logic [15:0] r_diff;
    logic [30:0] r_rem [DIV_STAGES+1];
    logic [15:0] r_quo [DIV_STAGES+1];
    logic [30:0] r_prod;
    logic [15:0] r_out;

    logic [15:0] raw_u;
    logic [15:0] mag;
    logic        below;
    logic [14:0] span;
    t_axis_side  n_side;

    assign raw_u = i_raw;
    assign mag = raw_u[15] ? (~raw_u + 16'd1) : raw_u;
    assign below = (mag < {1'b0, i_cfg.dz_thr}) || (i_cfg.dz_thr == AXIS_MAX);
    assign span = AXIS_MAX - i_cfg.dz_thr;

    always_comb begin
        n_side.raw = raw_u;
        n_side.neg = raw_u[15];
        n_side.zero = below;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_side[0] <= n_side;
            r_diff <= below ? 16'd0 : (mag - {1'b0, i_cfg.dz_thr});
        end
        if (i_en[1]) begin
            r_side[1] <= r_side[0];
            r_rem[0] <= {r_diff, 15'd0} - {15'd0, r_diff};
            r_quo[0] <= '0;
        end
        for (int k = 2; k < NUM_STAGES - 1; k++) begin
            if (i_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [30:0] n_rem;
        logic [15:0] n_quo;

        always_comb begin
            logic [30:0] rem;
            logic [15:0] quo;
            logic [30:0] trial;
            rem = r_rem[j];
            quo = r_quo[j];
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {16'd0, span} << (15 - DIV_BITS * j - b);
                if (rem >= trial) begin
                    rem = rem - trial;
                    quo[15 - DIV_BITS * j - b] = 1'b1;
                end
            end
            n_rem = rem;
            n_quo = quo;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[DIV_FIRST + j]) begin
                r_rem[j+1] <= n_rem;
                r_quo[j+1] <= n_quo;
            end
        end
    end

    localparam int GAIN_STAGE = DIV_FIRST + DIV_STAGES;
    localparam int OUT_STAGE = GAIN_STAGE + 1;

    logic [14:0] scaled;
    assign scaled = r_side[GAIN_STAGE-1].zero ? 15'd0
                  : (r_quo[DIV_STAGES][15] ? AXIS_MAX : r_quo[DIV_STAGES][14:0]);

    always_ff @(posedge i_clk) begin
        if (i_en[GAIN_STAGE]) begin
            r_prod <= {16'd0, scaled} * {15'd0, i_cfg.gain};
        end
    end

    logic [22:0] q;
    logic [15:0] gained;
    logic [15:0] inverted;
    logic        neg_last;

    assign q = r_prod[30:GAIN_FRAC];
    assign neg_last = r_side[GAIN_STAGE].neg;

    always_comb begin
        logic [15:0] qm;
        qm = (q > GAIN_NEG_LIMIT) ? AXIS_MIN_S : q[15:0];
        if (neg_last) begin
            gained = ~qm + 16'd1;
        end else begin
            gained = (q > GAIN_POS_LIMIT) ? AXIS_MAX_S : q[15:0];
        end
        if (!i_cfg.invert) begin
            inverted = gained;
        end else if (gained == AXIS_MIN_S) begin
            inverted = AXIS_MAX_S;
        end else begin
            inverted = ~gained + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[OUT_STAGE]) begin
            r_out <= i_cfg.enable ? inverted : r_side[GAIN_STAGE].raw;
        end
    end

    assign o_axis = r_out;

endmodule

// File: design/sac_checker.sv
// Port-level checks on the stick axis conditioner, attached by the bind below.
// Depends on sac_pkg for port widths.
module sac_checker
    import sac_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_INDEX_W-1:0] i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic signed [15:0]     i_raw_left_x,
    input logic signed [15:0]     i_raw_left_y,
    input logic signed [15:0]     i_raw_right_x,
    input logic signed [15:0]     i_raw_right_y,
    input logic [7:0]             i_raw_left_trigger,
    input logic [7:0]             i_raw_right_trigger,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic signed [15:0]     o_out_left_x,
    input logic signed [15:0]     o_out_left_y,
    input logic signed [15:0]     o_out_right_x,
    input logic signed [15:0]     o_out_right_y,
    input logic [7:0]             o_out_left_trigger,
    input logic [7:0]             o_out_right_trigger
);

    // Reset empties the pipeline, so no word may appear just after it.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // With the output free to move, every stage can advance and the input must be ready.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input not ready while the output can drain");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_left_x)
            && $stable(o_out_left_y) && $stable(o_out_right_x) && $stable(o_out_right_y)
            && $stable(o_out_left_trigger) && $stable(o_out_right_trigger)))
        else $error("stalled output word changed");

endmodule

bind stick_axis_conditioner_core sac_checker u_checker (.*);
